>>> src/uwf_pkg.sv
`default_nettype none
package uwf_pkg;

  parameter int unsigned ListEntriesDefault = 16;
  // Wide enough for every slot number and count that LIST_ENTRIES allows (up to 511).
  parameter int unsigned CmpW = 9;
  parameter int unsigned CountW = 5;

  typedef enum logic {
    CMD_EVENT = 1'b0,
    CMD_LOAD  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_ATTACH = 2'd0,
    SEL_DETACH = 2'd1,
    SEL_OTHER  = 2'd2,
    SEL_SPARE  = 2'd3
  } sel_e;

  typedef enum logic {
    REG_ATTACH_COUNT = 1'b0,
    REG_DETACH_COUNT = 1'b1
  } reg_e;

  parameter int unsigned FlagVendor   = 0;
  parameter int unsigned FlagProduct  = 1;
  parameter int unsigned FlagBcdLo    = 2;
  parameter int unsigned FlagBcdHi    = 3;
  parameter int unsigned FlagClass    = 4;
  parameter int unsigned FlagSubclass = 5;
  parameter int unsigned FlagProtocol = 6;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  list_or_event;
    logic [3:0]  entry_index;
    logic [6:0]  match_mask;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [15:0] bcd_low;
    logic [15:0] bcd_high;
    logic [15:0] bcd_device;
    logic [7:0]  device_class;
    logic [7:0]  device_subclass;
    logic [7:0]  device_protocol;
  } item_t;

  typedef struct packed {
    logic listed;
    logic power_off;
    logic checked_list;
  } result_t;

  typedef struct packed {
    logic [6:0]  mask;
    logic [15:0] vendor;
    logic [15:0] product;
    logic [7:0]  cls;
    logic [7:0]  subcls;
    logic [7:0]  proto;
  } ident_t;

  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
  } limit_t;

  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] product;
    logic [15:0] bcd;
    logic [7:0]  cls;
    logic [7:0]  subcls;
    logic [7:0]  proto;
  } device_t;

endpackage
`default_nettype wire

>>> src/uwf_ram.sv
`default_nettype none
module uwf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> src/uwf_match.sv
`default_nettype none
module uwf_match (
  input  wire uwf_pkg::ident_t  ident_i,
  input  wire uwf_pkg::limit_t  limit_i,
  input  wire uwf_pkg::device_t dev_i,
  output logic                  match_o
);

  logic [6:0] fail;

  always_comb begin
    fail = '0;
    fail[uwf_pkg::FlagVendor]   = ident_i.vendor != dev_i.vendor;
    fail[uwf_pkg::FlagProduct]  = ident_i.product != dev_i.product;
    fail[uwf_pkg::FlagBcdLo]    = limit_i.lo > dev_i.bcd;
    fail[uwf_pkg::FlagBcdHi]    = limit_i.hi < dev_i.bcd;
    fail[uwf_pkg::FlagClass]    = ident_i.cls != dev_i.cls;
    fail[uwf_pkg::FlagSubclass] = ident_i.subcls != dev_i.subcls;
    fail[uwf_pkg::FlagProtocol] = ident_i.proto != dev_i.proto;
    match_o = ~|(fail & ident_i.mask);
  end

endmodule
`default_nettype wire

>>> src/usb_device_whitelist_filter.sv
// A load item writes one whitelist entry when its list and slot are valid;
// busy stays low. An attach or detach event scans its list one entry per
// cycle through a registered memory read, so the result strobe done_o comes
// once the first count entries (count saturated at LIST_ENTRIES) are
// checked, earlier on the first match. done_o is high for a single cycle
// and cannot be held off, and result_o holds the result until the next one;
// a new item may be started in that same cycle. Other event kinds give
// no result. Counts are written on the cfg port, which is always ready.
`default_nettype none
module usb_device_whitelist_filter #(
  parameter int unsigned LIST_ENTRIES = uwf_pkg::ListEntriesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire uwf_pkg::item_t               item_i,
  output logic                              done_o,
  output uwf_pkg::result_t                  result_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_index_i,
  input  wire logic [uwf_pkg::CountW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW     = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned AddrW    = IdxW + 1;
  localparam int unsigned MemDepth = 2 ** AddrW;
  localparam int unsigned IdentW   = $bits(uwf_pkg::ident_t);
  localparam int unsigned LimitW   = $bits(uwf_pkg::limit_t);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  logic                         sel_q, sel_d;
  uwf_pkg::device_t             dev_q, dev_d;
  logic [CntW-1:0]              limit_q, limit_d;
  logic [CntW-1:0]              rd_q, rd_d;
  logic                         pend_q, pend_d;
  logic                         done_q, done_d;
  uwf_pkg::result_t             result_q, result_d;
  logic [uwf_pkg::CountW-1:0]   attach_cnt_q, detach_cnt_q;

  logic                         accept;
  logic                         is_list;
  logic                         slot_ok;
  logic                         we;
  logic [AddrW-1:0]             waddr;
  logic                         re;
  logic [AddrW-1:0]             raddr;
  logic [uwf_pkg::CountW-1:0]   cnt_sel;
  logic [uwf_pkg::CmpW-1:0]     cnt_sat;
  uwf_pkg::ident_t              ident_wr, ident_rd;
  uwf_pkg::limit_t              limit_wr, limit_rd;
  logic                         match;

  assign busy        = state_q != ST_IDLE;
  assign accept      = start & ~busy;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = result_q;

  assign is_list = (item_i.list_or_event == uwf_pkg::SEL_ATTACH) ||
                   (item_i.list_or_event == uwf_pkg::SEL_DETACH);
  assign slot_ok = {{(uwf_pkg::CmpW - 4){1'b0}}, item_i.entry_index} <
                   uwf_pkg::CmpW'(LIST_ENTRIES);
  assign we      = accept & (item_i.cmd == uwf_pkg::CMD_LOAD) & is_list & slot_ok;
  assign waddr   = {item_i.list_or_event[0], IdxW'(item_i.entry_index)};

  assign ident_wr = '{mask:    item_i.match_mask,
                      vendor:  item_i.vendor_id,
                      product: item_i.product_id,
                      cls:     item_i.device_class,
                      subcls:  item_i.device_subclass,
                      proto:   item_i.device_protocol};
  assign limit_wr = '{lo: item_i.bcd_low, hi: item_i.bcd_high};

  assign re    = (state_q == ST_SCAN) && (rd_q < limit_q);
  assign raddr = {sel_q, rd_q[IdxW-1:0]};

  uwf_ram #(
    .WIDTH (IdentW),
    .DEPTH (MemDepth)
  ) u_ident_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (ident_wr),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ident_rd)
  );

  uwf_ram #(
    .WIDTH (LimitW),
    .DEPTH (MemDepth)
  ) u_limit_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (limit_wr),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (limit_rd)
  );

  uwf_match u_match (
    .ident_i (ident_rd),
    .limit_i (limit_rd),
    .dev_i   (dev_q),
    .match_o (match)
  );

  assign cnt_sel = (item_i.list_or_event[0]) ? detach_cnt_q : attach_cnt_q;
  assign cnt_sat = ({{(uwf_pkg::CmpW - uwf_pkg::CountW){1'b0}}, cnt_sel} >
                    uwf_pkg::CmpW'(LIST_ENTRIES)) ?
                   uwf_pkg::CmpW'(LIST_ENTRIES) :
                   {{(uwf_pkg::CmpW - uwf_pkg::CountW){1'b0}}, cnt_sel};

  always_comb begin
    state_d  = state_q;
    sel_d    = sel_q;
    dev_d    = dev_q;
    limit_d  = limit_q;
    rd_d     = rd_q;
    pend_d   = pend_q;
    done_d   = 1'b0;
    result_d = result_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.cmd == uwf_pkg::CMD_EVENT) && is_list) begin
          state_d = ST_SCAN;
          sel_d   = item_i.list_or_event[0];
          dev_d   = '{vendor:  item_i.vendor_id,
                      product: item_i.product_id,
                      bcd:     item_i.bcd_device,
                      cls:     item_i.device_class,
                      subcls:  item_i.device_subclass,
                      proto:   item_i.device_protocol};
          limit_d = CntW'(cnt_sat);
          rd_d    = '0;
          pend_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (pend_q && match) begin
          state_d  = ST_IDLE;
          pend_d   = 1'b0;
          done_d   = 1'b1;
          result_d = '{listed: 1'b1, power_off: 1'b0, checked_list: sel_q};
        end else if (re) begin
          rd_d   = rd_q + CntW'(1);
          pend_d = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          result_d = '{listed: 1'b0, power_off: 1'b1, checked_list: sel_q};
        end
      end
      default: begin
        state_d = ST_IDLE;
        pend_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_q       <= 1'b0;
      done_q       <= 1'b0;
      attach_cnt_q <= '0;
      detach_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          uwf_pkg::REG_ATTACH_COUNT: attach_cnt_q <= cfg_data_i;
          uwf_pkg::REG_DETACH_COUNT: detach_cnt_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    dev_q    <= dev_d;
    limit_q  <= limit_d;
    rd_q     <= rd_d;
    result_q <= result_d;
  end

endmodule
`default_nettype wire

>>> bench/tb_top.sv
module tb_top;
  import uwf_pkg::*;

  localparam int unsigned LIST_ENTRIES = ListEntriesDefault;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned PhaseItems = 180;

  class whitelist_tracker;
    ident_t idents[2][LIST_ENTRIES];
    limit_t limits[2][LIST_ENTRIES];
    logic [CountW-1:0] counts[2];
    result_t pending_verdicts[$];
    int unsigned errors;

    function new();
      counts[0] = '0;
      counts[1] = '0;
      errors = 0;
    endfunction

    function void set_count(reg_e r, logic [CountW-1:0] v);
      counts[r] = v;
    endfunction

    function bit entry_admits(ident_t e, limit_t lim, item_t d);
      if (e.mask[FlagVendor] && e.vendor != d.vendor_id) return 1'b0;
      if (e.mask[FlagProduct] && e.product != d.product_id) return 1'b0;
      if (e.mask[FlagBcdLo] && lim.lo > d.bcd_device) return 1'b0;
      if (e.mask[FlagBcdHi] && lim.hi < d.bcd_device) return 1'b0;
      if (e.mask[FlagClass] && e.cls != d.device_class) return 1'b0;
      if (e.mask[FlagSubclass] && e.subcls != d.device_subclass) return 1'b0;
      if (e.mask[FlagProtocol] && e.proto != d.device_protocol) return 1'b0;
      return 1'b1;
    endfunction

    function void note_item(item_t it);
      int unsigned scan_len;
      int unsigned l;
      bit hit;
      result_t verdict;
      if (it.list_or_event != SEL_ATTACH && it.list_or_event != SEL_DETACH) return;
      l = it.list_or_event[0];
      if (it.cmd == CMD_LOAD) begin
        idents[l][it.entry_index] = {it.match_mask, it.vendor_id, it.product_id,
                                     it.device_class, it.device_subclass,
                                     it.device_protocol};
        limits[l][it.entry_index] = {it.bcd_low, it.bcd_high};
        return;
      end
      scan_len = (counts[l] > LIST_ENTRIES) ? LIST_ENTRIES : counts[l];
      hit = 1'b0;
      for (int i = 0; i < scan_len && !hit; i++) begin
        hit = entry_admits(idents[l][i], limits[l][i], it);
      end
      verdict.listed = hit;
      verdict.power_off = !hit;
      verdict.checked_list = l[0];
      pending_verdicts.push_back(verdict);
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result %b", $time, got);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.listed !== want.listed) begin
        $display("%0t: listed expected %b actual %b", $time, want.listed, got.listed);
        errors++;
      end
      if (got.power_off !== want.power_off) begin
        $display("%0t: power_off expected %b actual %b", $time, want.power_off,
                 got.power_off);
        errors++;
      end
      if (got.checked_list !== want.checked_list) begin
        $display("%0t: checked_list expected %b actual %b", $time, want.checked_list,
                 got.checked_list);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  item_t item;
  logic done;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [CountW-1:0] cfg_data;

  whitelist_tracker tracker;
  item_t dev_pool[8];
  int unsigned cycle_count = 0;

  usb_device_whitelist_filter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("usb_device_whitelist_filter verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && done) tracker.check_verdict(result);
  end

  function automatic item_t noise_item();
    logic [159:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic logic [15:0] near(logic [15:0] v);
    return v + 16'($urandom_range(0, 6)) - 16'd3;
  endfunction

  function automatic item_t make_load(logic [1:0] lst, logic [3:0] idx);
    item_t it;
    item_t d;
    it = noise_item();
    d = dev_pool[$urandom_range(0, 7)];
    it.cmd = CMD_LOAD;
    it.list_or_event = lst;
    it.entry_index = idx;
    if ($urandom_range(0, 9) < 8) begin
      it.vendor_id = d.vendor_id;
      it.product_id = d.product_id;
      it.device_class = d.device_class;
      it.device_subclass = d.device_subclass;
      it.device_protocol = d.device_protocol;
      it.bcd_low = near(d.bcd_device);
      it.bcd_high = near(d.bcd_device);
    end
    if ($urandom_range(0, 9) == 0) it.match_mask = '0;
    return it;
  endfunction

  function automatic item_t make_event(logic [1:0] sel);
    item_t it;
    item_t d;
    it = noise_item();
    it.cmd = CMD_EVENT;
    it.list_or_event = sel;
    if ($urandom_range(0, 3) != 0) begin
      d = dev_pool[$urandom_range(0, 7)];
      it.vendor_id = d.vendor_id;
      it.product_id = d.product_id;
      it.device_class = d.device_class;
      it.device_subclass = d.device_subclass;
      it.device_protocol = d.device_protocol;
      it.bcd_device = near(d.bcd_device);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: it.vendor_id[$urandom_range(0, 15)] ^= 1'b1;
          1: it.product_id[$urandom_range(0, 15)] ^= 1'b1;
          2: it.device_class[$urandom_range(0, 7)] ^= 1'b1;
          3: it.device_subclass[$urandom_range(0, 7)] ^= 1'b1;
          default: it.device_protocol[$urandom_range(0, 7)] ^= 1'b1;
        endcase
      end
    end
    return it;
  endfunction

  function automatic item_t random_item();
    int unsigned r;
    item_t it;
    r = $urandom_range(0, 99);
    if (r < 20) return make_load(2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    if (r < 90) return make_event(2'($urandom_range(0, 1)));
    it = noise_item();
    if (r < 95) it.list_or_event[1] = 1'b1;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    tracker.note_item(it);
  endtask

  task automatic idle_gap(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (LIST_ENTRIES + 4) @(posedge clk);
  endtask

  task automatic write_count(input reg_e r, input logic [CountW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_count(r, v);
  endtask

  task automatic set_counts(input logic [CountW-1:0] a, input logic [CountW-1:0] d);
    write_count(REG_ATTACH_COUNT, a);
    write_count(REG_DETACH_COUNT, d);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    item_t it;
    logic [CountW-1:0] a_cnt;
    logic [CountW-1:0] d_cnt;
    bit gappy;

    tracker = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ATTACH_COUNT;
    cfg_data <= '0;
    for (int i = 0; i < 8; i++) dev_pool[i] = noise_item();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both lists are empty after reset, so every attach or detach event asks for power-off.
    send_item(make_event(SEL_ATTACH));
    it = '0;
    it.list_or_event = SEL_DETACH;
    send_item(it);
    it = '1;
    it.cmd = CMD_EVENT;
    it.list_or_event = SEL_OTHER;
    send_item(it);
    it.list_or_event = SEL_SPARE;
    send_item(it);
    it = '1;
    it.list_or_event = SEL_OTHER;
    send_item(it);
    it.list_or_event = SEL_SPARE;
    send_item(it);

    // Every slot is written before any count lets a scan reach it.
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      it = make_load(SEL_ATTACH, 4'(i));
      if (i == 0) it.match_mask = '0;
      if (i == 1) begin
        it = '1;
        it.list_or_event = SEL_ATTACH;
        it.entry_index = 4'(i);
      end
      send_item(it);
      it = make_load(SEL_DETACH, 4'(i));
      if (i < 8) begin
        it.vendor_id = dev_pool[0].vendor_id;
        it.product_id = dev_pool[0].product_id;
        it.device_class = dev_pool[0].device_class;
        it.device_subclass = dev_pool[0].device_subclass;
        it.device_protocol = dev_pool[0].device_protocol;
        it.bcd_low = dev_pool[0].bcd_device;
        it.bcd_high = dev_pool[0].bcd_device;
        it.match_mask = (i == 7) ? 7'h7f : 7'(1 << i);
      end
      send_item(it);
    end

    settle();
    set_counts(5'd1, 5'd16);
    send_item(make_event(SEL_ATTACH));
    it = dev_pool[0];
    it.cmd = CMD_EVENT;
    it.list_or_event = SEL_DETACH;
    send_item(it);
    it = '0;
    it.list_or_event = SEL_DETACH;
    send_item(it);
    it = '1;
    it.cmd = CMD_EVENT;
    it.list_or_event = SEL_DETACH;
    send_item(it);
    it.list_or_event = SEL_ATTACH;
    send_item(it);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          a_cnt = 5'd16;
          d_cnt = 5'd16;
        end
        1: begin
          a_cnt = 5'd1;
          d_cnt = 5'd31;
        end
        2: begin
          a_cnt = 5'd31;
          d_cnt = 5'd0;
        end
        3: begin
          a_cnt = 5'd0;
          d_cnt = 5'd1;
        end
        default: begin
          a_cnt = 5'($urandom_range(0, 31));
          d_cnt = 5'($urandom_range(0, 31));
        end
      endcase
      gappy = (p < 8) && ($urandom_range(0, 4) != 0);
      dev_pool[p % 8] = noise_item();
      settle();
      set_counts(a_cnt, d_cnt);
      for (int n = 0; n < PhaseItems; n++) begin
        send_item(random_item());
        if (gappy && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 6));
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.pending_verdicts.size() == 0) begin
      $display("usb_device_whitelist_filter verification clean");
    end else begin
      $display("usb_device_whitelist_filter verification failed");
    end
    $finish;
  end

endmodule
